FILE: rtl/bgham_pkg.sv
// Shared types, widths, alarm bit positions and thresholds of the blood gas alarm monitor.
package bgham_pkg;

    // Default saturation point of the per-cycle sample count
    localparam int unsigned MAX_SAMPLES_DEF = 255;

    // Field and storage widths
    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned NA_W     = 14;
    localparam int unsigned SUM_W    = 24;
    localparam int unsigned ALARM_W  = 11;
    localparam int unsigned QUO_W    = 16;
    localparam int unsigned STEP_W   = $clog2(QUO_W);

    localparam logic [SUM_W-1:0]  SUM_MAX   = '1;
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(QUO_W - 1);

    // Alarm bit positions
    localparam int unsigned A_HYPERCAP   = 0;
    localparam int unsigned A_HYPOX      = 1;
    localparam int unsigned A_MODHYPEROX = 2;
    localparam int unsigned A_SEVHYPEROX = 3;
    localparam int unsigned A_MODHYPOCAP = 4;
    localparam int unsigned A_SEVHYPOCAP = 5;
    localparam int unsigned A_HYPONA     = 6;
    localparam int unsigned A_HYPERNA    = 7;
    localparam int unsigned A_BRAIN      = 8;
    localparam int unsigned A_CRITBRAIN  = 9;
    localparam int unsigned A_MYO        = 10;

    // Thresholds in 1/64 units
    localparam logic [SAMPLE_W-1:0] CO2_HYPERCAP_SET = 16'd3840;
    localparam logic [SAMPLE_W-1:0] CO2_HYPERCAP_CLR = 16'd3648;
    localparam logic [SAMPLE_W-1:0] O2_HYPOX_SET     = 16'd4160;
    localparam logic [SAMPLE_W-1:0] O2_HYPOX_CLR     = 16'd4352;
    localparam logic [SAMPLE_W-1:0] O2_SEVHYPEROX    = 16'd12800;
    localparam logic [SAMPLE_W-1:0] O2_MODHYPEROX    = 16'd7680;
    localparam logic [SAMPLE_W-1:0] O2_HYPEROX_CLR   = 16'd7488;
    localparam logic [SAMPLE_W-1:0] CO2_SEVHYPOCAP   = 16'd960;
    localparam logic [SAMPLE_W-1:0] CO2_MODHYPOCAP   = 16'd1920;
    localparam logic [SAMPLE_W-1:0] CO2_HYPOCAP_CLR  = 16'd2112;
    localparam logic [NA_W-1:0]     NA_HYPO_SET      = 14'd8640;
    localparam logic [NA_W-1:0]     NA_HYPO_HOLD     = 14'd8704;
    localparam logic [NA_W-1:0]     NA_HYPER_SET     = 14'd9280;
    localparam logic [NA_W-1:0]     NA_HYPER_HOLD    = 14'd9216;
    localparam logic [SAMPLE_W-1:0] BRAIN_SET        = 16'd1216;
    localparam logic [SAMPLE_W-1:0] BRAIN_CLR        = 16'd1600;
    localparam logic [SAMPLE_W-1:0] CRITBRAIN_SET    = 16'd640;
    localparam logic [SAMPLE_W-1:0] CRITBRAIN_CLR    = 16'd768;
    localparam logic [SAMPLE_W-1:0] MYO_SET          = 16'd320;
    localparam logic [SAMPLE_W-1:0] MYO_CLR          = 16'd512;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;   // capture input word and accumulate
        logic load;     // load divider with a sum
        logic sel_co2;  // divider operand select: 0 O2 sum, 1 CO2 sum
        logic step;     // one restoring division step
        logic save_o2;  // keep the O2 quotient
        logic finish;   // update alarms, clear on cycle start, load output
    } bgham_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic out_full; // output word present and not taken this cycle
    } bgham_status_t;

endpackage

FILE: rtl/bgham_alarm.sv
// Hysteresis alarm next-state logic for cycle and tissue alarms.
module bgham_alarm import bgham_pkg::*;
(
    input  logic [ALARM_W-1:0]  state_in,
    input  logic [SAMPLE_W-1:0] mean_o2,
    input  logic [SAMPLE_W-1:0] mean_co2,
    input  logic [NA_W-1:0]     sodium,
    input  logic [SAMPLE_W-1:0] brain,
    input  logic [SAMPLE_W-1:0] myo,
    input  logic                cycle_en,
    input  logic                tissue_en,
    output logic [ALARM_W-1:0]  state_out
);

    // Evaluate cycle alarms from the means, then tissue alarms from the readings
    always_comb
    begin
        state_out = state_in;

        if (cycle_en)
        begin
            if (mean_co2 >= CO2_HYPERCAP_SET)
                state_out[A_HYPERCAP] = 1'b1;
            else if (mean_co2 < CO2_HYPERCAP_CLR)
                state_out[A_HYPERCAP] = 1'b0;

            if (mean_o2 <= O2_HYPOX_SET)
                state_out[A_HYPOX] = 1'b1;
            else if (mean_o2 > O2_HYPOX_CLR)
                state_out[A_HYPOX] = 1'b0;

            if (mean_o2 > O2_SEVHYPEROX)
            begin
                state_out[A_SEVHYPEROX] = 1'b1;
                state_out[A_MODHYPEROX] = 1'b0;
            end
            else if (mean_o2 > O2_MODHYPEROX)
            begin
                state_out[A_SEVHYPEROX] = 1'b0;
                state_out[A_MODHYPEROX] = 1'b1;
            end
            else if (mean_o2 < O2_HYPEROX_CLR)
            begin
                state_out[A_SEVHYPEROX] = 1'b0;
                state_out[A_MODHYPEROX] = 1'b0;
            end

            if (mean_co2 < CO2_SEVHYPOCAP)
            begin
                state_out[A_SEVHYPOCAP] = 1'b1;
                state_out[A_MODHYPOCAP] = 1'b0;
            end
            else if (mean_co2 < CO2_MODHYPOCAP)
            begin
                state_out[A_SEVHYPOCAP] = 1'b0;
                state_out[A_MODHYPOCAP] = 1'b1;
            end
            else if (mean_co2 > CO2_HYPOCAP_CLR)
            begin
                state_out[A_SEVHYPOCAP] = 1'b0;
                state_out[A_MODHYPOCAP] = 1'b0;
            end

            // Sodium: wider band holds an alarm that is already on
            if (sodium < NA_HYPO_SET || (state_in[A_HYPONA] && sodium < NA_HYPO_HOLD))
            begin
                state_out[A_HYPONA]  = 1'b1;
                state_out[A_HYPERNA] = 1'b0;
            end
            else if (sodium > NA_HYPER_SET ||
                     (state_in[A_HYPERNA] && sodium > NA_HYPER_HOLD))
            begin
                state_out[A_HYPONA]  = 1'b0;
                state_out[A_HYPERNA] = 1'b1;
            end
            else
            begin
                state_out[A_HYPONA]  = 1'b0;
                state_out[A_HYPERNA] = 1'b0;
            end
        end

        if (tissue_en)
        begin
            // Critical brain alarm moves only below BRAIN_SET or as brain clears
            if (brain < BRAIN_SET)
            begin
                state_out[A_BRAIN] = 1'b1;
                if (brain < CRITBRAIN_SET)
                    state_out[A_CRITBRAIN] = 1'b1;
                else if (brain > CRITBRAIN_CLR)
                    state_out[A_CRITBRAIN] = 1'b0;
            end
            else if (brain > BRAIN_CLR)
            begin
                state_out[A_BRAIN]     = 1'b0;
                state_out[A_CRITBRAIN] = 1'b0;
            end

            if (myo < MYO_SET)
                state_out[A_MYO] = 1'b1;
            else if (myo > MYO_CLR)
                state_out[A_MYO] = 1'b0;
        end
    end

endmodule

FILE: rtl/bgham_dp.sv
// Datapath: input capture, running sums, shared restoring divider, alarm state, output register.
module bgham_dp import bgham_pkg::*;
#(
    parameter int unsigned MAX_SAMPLES = MAX_SAMPLES_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  bgham_cmd_t            cmd,
    output bgham_status_t         status,
    input  logic [79:0]           s_tdata,
    input  logic [2:0]            s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [47:0]           m_tdata
);

    localparam int unsigned     CNT_W   = $clog2(MAX_SAMPLES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SAMPLES);

    // Captured input word
    logic [SAMPLE_W-1:0] brain_reg, myo_reg;
    logic [NA_W-1:0]     na_reg;
    logic                start_reg, active_reg, past_reg;

    // Running sums and count
    logic [SUM_W-1:0] o2_sum_reg, o2_sum_next;
    logic [SUM_W-1:0] co2_sum_reg, co2_sum_next;
    logic [CNT_W-1:0] count_reg, count_next;

    // Divider
    logic [CNT_W-1:0]    rem_reg;
    logic [QUO_W-1:0]    dvd_reg;
    logic [QUO_W-1:0]    quo_reg;
    logic [SUM_W-1:0]    div_src;
    logic [CNT_W:0]      trial;
    logic [CNT_W:0]      diff;
    logic                ge;

    // Alarm state and output
    logic [ALARM_W-1:0]  alarm_reg, alarm_next;
    logic [SAMPLE_W-1:0] mean_o2_reg;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [47:0]         m_tdata_reg;

    logic [SUM_W:0] o2_add, co2_add;

    // Capture input word on accept
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            brain_reg  <= s_tdata[47:32];
            myo_reg    <= s_tdata[63:48];
            na_reg     <= s_tdata[77:64];
            start_reg  <= s_tuser[0];
            active_reg <= s_tuser[1];
            past_reg   <= s_tuser[2];
        end
    end

    // Accumulate with saturation; drop samples once the count is full
    assign o2_add  = {1'b0, o2_sum_reg}  + {{(SUM_W + 1 - SAMPLE_W){1'b0}}, s_tdata[15:0]};
    assign co2_add = {1'b0, co2_sum_reg} + {{(SUM_W + 1 - SAMPLE_W){1'b0}}, s_tdata[31:16]};

    always_comb
    begin
        o2_sum_next  = o2_sum_reg;
        co2_sum_next = co2_sum_reg;
        count_next   = count_reg;
        if (cmd.accept && count_reg < CNT_MAX)
        begin
            o2_sum_next  = o2_add[SUM_W]  ? SUM_MAX : o2_add[SUM_W-1:0];
            co2_sum_next = co2_add[SUM_W] ? SUM_MAX : co2_add[SUM_W-1:0];
            count_next   = count_reg + 1'b1;
        end
        else if (cmd.finish && start_reg)
        begin
            o2_sum_next  = '0;
            co2_sum_next = '0;
            count_next   = '0;
        end
    end

    // Divider step: quotient fits 16 bits, so the top sum byte is below the count
    assign div_src = cmd.sel_co2 ? co2_sum_reg : o2_sum_reg;
    assign trial   = {rem_reg, dvd_reg[QUO_W-1]};
    assign diff    = trial - {1'b0, count_reg};
    assign ge      = (trial >= {1'b0, count_reg});

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            rem_reg <= CNT_W'(div_src[SUM_W-1:QUO_W]);
            dvd_reg <= div_src[QUO_W-1:0];
            quo_reg <= '0;
        end
        else if (cmd.step)
        begin
            rem_reg <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
            dvd_reg <= {dvd_reg[QUO_W-2:0], 1'b0};
            quo_reg <= {quo_reg[QUO_W-2:0], ge};
        end
        if (cmd.save_o2)
            mean_o2_reg <= quo_reg;
    end

    // Alarm next state from the means and the captured readings
    bgham_alarm u_alarm
    (
        .state_in  (alarm_reg),
        .mean_o2   (mean_o2_reg),
        .mean_co2  (quo_reg),
        .sodium    (na_reg),
        .brain     (brain_reg),
        .myo       (myo_reg),
        .cycle_en  (start_reg & active_reg),
        .tissue_en (past_reg),
        .state_out (alarm_next)
    );

    // Output valid: set on finish, drop when taken
    always_comb
    begin
        if (cmd.finish)
            m_tvalid_next = 1'b1;
        else if (m_tready)
            m_tvalid_next = 1'b0;
        else
            m_tvalid_next = m_tvalid_reg;
    end

    // Hold control state and sums
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o2_sum_reg   <= '0;
            co2_sum_reg  <= '0;
            count_reg    <= '0;
            alarm_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            o2_sum_reg   <= o2_sum_next;
            co2_sum_reg  <= co2_sum_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cmd.finish)
                alarm_reg <= alarm_next;
        end
    end

    // Load result word
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
            m_tdata_reg <= {5'b0, quo_reg, mean_o2_reg, alarm_next};
    end

    assign m_tvalid        = m_tvalid_reg;
    assign m_tdata         = m_tdata_reg;
    assign status.out_full = m_tvalid_reg & ~m_tready;

endmodule

FILE: rtl/bgham_ctrl.sv
// Controller: sequences accept, the two mean divisions and the result handoff.
module bgham_ctrl import bgham_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  bgham_status_t status,
    output bgham_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD_O2,
        ST_DIV_O2,
        ST_LOAD_CO2,
        ST_DIV_CO2,
        ST_FINISH
    } state_t;

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;

    // Decode commands from the current state
    always_comb
    begin
        cmd        = '0;
        s_tready   = 1'b0;
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
                if (s_tvalid)
                    state_next = ST_LOAD_O2;
            end
            ST_LOAD_O2:
            begin
                cmd.load   = 1'b1;
                step_next  = '0;
                state_next = ST_DIV_O2;
            end
            ST_DIV_O2:
            begin
                cmd.step  = 1'b1;
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_LAST)
                    state_next = ST_LOAD_CO2;
            end
            ST_LOAD_CO2:
            begin
                cmd.save_o2 = 1'b1;
                cmd.load    = 1'b1;
                cmd.sel_co2 = 1'b1;
                step_next   = '0;
                state_next  = ST_DIV_CO2;
            end
            ST_DIV_CO2:
            begin
                cmd.step  = 1'b1;
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_LAST)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!status.out_full)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and step count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

FILE: rtl/blood_gas_hysteresis_alarm_monitor.sv
// Top level of the blood gas hysteresis alarm monitor.
//
//   channel  direction  word contents
//   s_*      in         readings (tdata) and cycle/engine/stabilization flags (tuser)
//   m_*      out        alarm flags and the two running means (tdata)
//
// Each word passes through an accept state, two 16-step restoring divisions
// on one shared divider (O2 mean, then CO2 mean), each after a load state,
// and a finish state that updates the alarms; s_tready is high only in idle.
// The finish cycle waits while the previous result is still held on m_*.
// Reset clears sums, sample count and all alarms; no clearing pass is needed.
module blood_gas_hysteresis_alarm_monitor import bgham_pkg::*;
#(
    parameter int unsigned MAX_SAMPLES = MAX_SAMPLES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [15:0] arterial_o2, [31:16] arterial_co2, [47:32] brain_o2,
    // [63:48] heart_muscle_o2, [77:64] sodium_level, [79:78] zero
    input  logic [79:0] s_tdata,
    // [0] cycle_start, [1] engine_active, [2] past_stabilization
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [10:0] alarm_flags, [26:11] mean_o2, [42:27] mean_co2, [47:43] zero
    output logic [47:0] m_tdata
);

    bgham_cmd_t    cmd;
    bgham_status_t status;

    // Sequence the work
    bgham_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Do the arithmetic and hold the state
    bgham_dp #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_dp
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

FILE: verif/tb_top.sv
// Self-checking testbench of the blood gas hysteresis alarm monitor.
module tb_top import bgham_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned RAND_WORDS  = 1200;
    localparam int unsigned CYCLE_LIMIT = 600000;
    localparam int unsigned DRAIN_WAIT  = 60;
    localparam int unsigned PLAN_LEN    = 18;

    // One input word as the block sees it
    typedef struct packed {
        logic [SAMPLE_W-1:0] o2;
        logic [SAMPLE_W-1:0] co2;
        logic [SAMPLE_W-1:0] brain;
        logic [SAMPLE_W-1:0] myo;
        logic [NA_W-1:0]     na;
        logic                start;
        logic                active;
        logic                past;
    } gas_reading_t;

    // One output word
    typedef struct packed {
        logic [ALARM_W-1:0]  flags;
        logic [SAMPLE_W-1:0] mean_o2;
        logic [SAMPLE_W-1:0] mean_co2;
    } gas_result_t;

    // Directed row: the word to send and, where obvious, the word to expect
    typedef struct packed {
        gas_reading_t rd;
        logic         typed;
        gas_result_t  want;
    } plan_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;

    // Predictor state
    logic [SUM_W-1:0]   o2_acc = '0;
    logic [SUM_W-1:0]   co2_acc = '0;
    int unsigned        n_samples = 0;
    logic [ALARM_W-1:0] alarm_reg = '0;

    gas_result_t pending_results[$];
    int unsigned errors = 0;
    int unsigned words_checked = 0;
    int unsigned cycle_evals = 0;
    int unsigned capped_cycles = 0;
    int unsigned cycle_cnt = 0;
    logic        no_idle = 1'b0;

    int unsigned o2_marks [5] = '{O2_HYPOX_SET, O2_HYPOX_CLR, O2_HYPEROX_CLR,
                                  O2_MODHYPEROX, O2_SEVHYPEROX};
    int unsigned co2_marks [5] = '{CO2_SEVHYPOCAP, CO2_MODHYPOCAP, CO2_HYPOCAP_CLR,
                                   CO2_HYPERCAP_CLR, CO2_HYPERCAP_SET};
    int unsigned brain_marks [4] = '{CRITBRAIN_SET, CRITBRAIN_CLR, BRAIN_SET, BRAIN_CLR};
    int unsigned myo_marks [2] = '{MYO_SET, MYO_CLR};
    int unsigned na_marks [4] = '{NA_HYPO_SET, NA_HYPO_HOLD, NA_HYPER_HOLD, NA_HYPER_SET};

    // Fields: o2, co2, brain, myo, na, start, active, past
    plan_row_t plan [PLAN_LEN] = '{
        // all readings zero: every low-side alarm trips, hypocapnia as severe only
        '{'{16'd0, 16'd0, 16'd0, 16'd0, 14'd0, 1'b1, 1'b1, 1'b1}, 1'b1,
          '{11'd1890, 16'd0, 16'd0}},
        // all readings at full scale: high-side alarms, tissue alarms clear
        '{'{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 14'h3FFF, 1'b1, 1'b1, 1'b1}, 1'b1,
          '{11'd137, 16'hFFFF, 16'hFFFF}},
        // walk the set, hold and clear edges of each hysteresis band
        '{'{16'd4160, 16'd3840, 16'd1215, 16'd319, 14'd8639, 1'b1, 1'b1, 1'b1}, 1'b0, '0},
        '{'{16'd4352, 16'd3648, 16'd639, 16'd320, 14'd8703, 1'b1, 1'b1, 1'b1}, 1'b0, '0},
        '{'{16'd4353, 16'd3647, 16'd768, 16'd512, 14'd8704, 1'b1, 1'b1, 1'b1}, 1'b0, '0},
        '{'{16'd12801, 16'd959, 16'd769, 16'd513, 14'd9281, 1'b1, 1'b1, 1'b1}, 1'b0, '0},
        '{'{16'd12800, 16'd960, 16'd1216, 16'd0, 14'd9217, 1'b1, 1'b1, 1'b1}, 1'b0, '0},
        '{'{16'd7680, 16'd1920, 16'd1600, 16'd0, 14'd9216, 1'b1, 1'b1, 1'b1}, 1'b0, '0},
        '{'{16'd7488, 16'd2112, 16'd1601, 16'd0, 14'd9280, 1'b1, 1'b1, 1'b0}, 1'b0, '0},
        '{'{16'd7487, 16'd2113, 16'd0, 16'd0, 14'd8640, 1'b1, 1'b1, 1'b0}, 1'b0, '0},
        // cycle start with the engine stopped: cycle alarms hold
        '{'{16'd0, 16'd0, 16'd0, 16'd0, 14'd0, 1'b1, 1'b0, 1'b1}, 1'b0, '0},
        // multi-sample cycle with a truncating mean
        '{'{16'd1000, 16'd2000, 16'd5000, 16'd5000, 14'd9000, 1'b0, 1'b1, 1'b1}, 1'b0, '0},
        '{'{16'd3001, 16'd5000, 16'd700, 16'd400, 14'd9000, 1'b0, 1'b1, 1'b1}, 1'b0, '0},
        '{'{16'd2000, 16'd4000, 16'd600, 16'd300, 14'd9000, 1'b1, 1'b1, 1'b1}, 1'b0, '0},
        // accumulate then drop the sums on a stopped-engine start
        '{'{16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 14'd0, 1'b0, 1'b1, 1'b0}, 1'b0, '0},
        '{'{16'd1, 16'd1, 16'd0, 16'd0, 14'd0, 1'b0, 1'b1, 1'b0}, 1'b0, '0},
        '{'{16'd100, 16'd100, 16'd0, 16'd0, 14'd0, 1'b1, 1'b0, 1'b0}, 1'b0, '0},
        '{'{16'd5000, 16'd3000, 16'd2000, 16'd600, 14'd9000, 1'b1, 1'b1, 1'b1}, 1'b0, '0}
    };

    blood_gas_hysteresis_alarm_monitor dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Free-running clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // Hold reset, then release it on a falling edge
    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    // Advance the predictor by one word and return the word it should produce
    function automatic gas_result_t advance_blood_gas(gas_reading_t r);
        gas_result_t        res;
        logic [SUM_W:0]     o2_next;
        logic [SUM_W:0]     co2_next;
        logic [ALARM_W-1:0] st;
        logic [SAMPLE_W-1:0] mo2;
        logic [SAMPLE_W-1:0] mco2;
        // accumulate unless the count is capped
        if (n_samples < MAX_SAMPLES_DEF)
        begin
            o2_next = {1'b0, o2_acc} + r.o2;
            co2_next = {1'b0, co2_acc} + r.co2;
            o2_acc = (o2_next > SUM_MAX) ? SUM_MAX : o2_next[SUM_W-1:0];
            co2_acc = (co2_next > SUM_MAX) ? SUM_MAX : co2_next[SUM_W-1:0];
            n_samples++;
            if (n_samples == MAX_SAMPLES_DEF)
                capped_cycles++;
        end
        mo2 = SAMPLE_W'(o2_acc / n_samples);
        mco2 = SAMPLE_W'(co2_acc / n_samples);
        st = alarm_reg;
        // cycle alarms from the means, then clear the sums
        if (r.start)
        begin
            if (r.active)
            begin
                cycle_evals++;
                if (mco2 >= CO2_HYPERCAP_SET)
                    st[A_HYPERCAP] = 1'b1;
                else if (mco2 < CO2_HYPERCAP_CLR)
                    st[A_HYPERCAP] = 1'b0;
                if (mo2 <= O2_HYPOX_SET)
                    st[A_HYPOX] = 1'b1;
                else if (mo2 > O2_HYPOX_CLR)
                    st[A_HYPOX] = 1'b0;
                if (mo2 > O2_SEVHYPEROX)
                begin
                    st[A_SEVHYPEROX] = 1'b1;
                    st[A_MODHYPEROX] = 1'b0;
                end
                else if (mo2 > O2_MODHYPEROX)
                begin
                    st[A_SEVHYPEROX] = 1'b0;
                    st[A_MODHYPEROX] = 1'b1;
                end
                else if (mo2 < O2_HYPEROX_CLR)
                begin
                    st[A_SEVHYPEROX] = 1'b0;
                    st[A_MODHYPEROX] = 1'b0;
                end
                if (mco2 < CO2_SEVHYPOCAP)
                begin
                    st[A_SEVHYPOCAP] = 1'b1;
                    st[A_MODHYPOCAP] = 1'b0;
                end
                else if (mco2 < CO2_MODHYPOCAP)
                begin
                    st[A_SEVHYPOCAP] = 1'b0;
                    st[A_MODHYPOCAP] = 1'b1;
                end
                else if (mco2 > CO2_HYPOCAP_CLR)
                begin
                    st[A_SEVHYPOCAP] = 1'b0;
                    st[A_MODHYPOCAP] = 1'b0;
                end
                if (r.na < NA_HYPO_SET || (st[A_HYPONA] && r.na < NA_HYPO_HOLD))
                begin
                    st[A_HYPONA] = 1'b1;
                    st[A_HYPERNA] = 1'b0;
                end
                else if (r.na > NA_HYPER_SET || (st[A_HYPERNA] && r.na > NA_HYPER_HOLD))
                begin
                    st[A_HYPONA] = 1'b0;
                    st[A_HYPERNA] = 1'b1;
                end
                else
                begin
                    st[A_HYPONA] = 1'b0;
                    st[A_HYPERNA] = 1'b0;
                end
            end
            o2_acc = '0;
            co2_acc = '0;
            n_samples = 0;
        end
        // tissue alarms update on every word once stabilized
        if (r.past)
        begin
            if (r.brain < BRAIN_SET)
            begin
                st[A_BRAIN] = 1'b1;
                if (r.brain < CRITBRAIN_SET)
                    st[A_CRITBRAIN] = 1'b1;
                else if (r.brain > CRITBRAIN_CLR)
                    st[A_CRITBRAIN] = 1'b0;
            end
            else if (r.brain > BRAIN_CLR)
            begin
                st[A_BRAIN] = 1'b0;
                st[A_CRITBRAIN] = 1'b0;
            end
            if (r.myo < MYO_SET)
                st[A_MYO] = 1'b1;
            else if (r.myo > MYO_CLR)
                st[A_MYO] = 1'b0;
        end
        alarm_reg = st;
        res.flags = st;
        res.mean_o2 = mo2;
        res.mean_co2 = mco2;
        return res;
    endfunction

    // Value scattered around a threshold, clamped to 16 bits
    function automatic logic [15:0] near_mark(int unsigned mark, int unsigned spread);
        int v;
        v = int'(mark) + int'($urandom_range(0, 2 * spread)) - int'(spread);
        if (v < 0)
            v = 0;
        if (v > 65535)
            v = 65535;
        return 16'(v);
    endfunction

    // Drive one word after a random gap and record what it should produce
    task automatic send_reading(gas_reading_t r, logic typed, gas_result_t want);
        int unsigned gap;
        gas_result_t predicted;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {2'b00, r.na, r.myo, r.brain, r.co2, r.o2};
        s_tuser <= {r.past, r.active, r.start};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predicted = advance_blood_gas(r);
        pending_results.push_back(typed ? want : predicted);
        @(negedge clk);
    endtask

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    // Receiver: stall a random number of cycles once a word is offered
    initial
    begin
        int unsigned stall;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 9);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                @(posedge clk);
                while (!m_tvalid)
                    @(posedge clk);
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
            @(negedge clk);
        end
    end

    // Compare every accepted output word with the oldest expectation
    always @(posedge clk)
    begin
        gas_result_t exp_word;
        gas_result_t got_word;
        if (rst_n && m_tvalid && m_tready)
        begin
            got_word.flags = m_tdata[10:0];
            got_word.mean_o2 = m_tdata[26:11];
            got_word.mean_co2 = m_tdata[42:27];
            if (pending_results.size() == 0)
            begin
                report_mismatch("pending word count", 0, 1);
            end
            else
            begin
                exp_word = pending_results.pop_front();
                words_checked++;
                if (got_word.flags != exp_word.flags)
                    report_mismatch("alarm_flags", got_word.flags, exp_word.flags);
                if (got_word.mean_o2 != exp_word.mean_o2)
                    report_mismatch("mean_o2", got_word.mean_o2, exp_word.mean_o2);
                if (got_word.mean_co2 != exp_word.mean_co2)
                    report_mismatch("mean_co2", got_word.mean_co2, exp_word.mean_co2);
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words pending",
                     cycle_cnt, pending_results.size());
            $display("** blood_gas_hysteresis_alarm_monitor: FAILED **");
            $finish;
        end
    end

    // Stimulus: directed table, then random cardiac cycles
    initial
    begin
        gas_reading_t r;
        int unsigned  rand_sent;
        int unsigned  run_len;
        int unsigned  o2_base;
        int unsigned  co2_base;
        logic         run_active;
        @(posedge rst_n);
        @(negedge clk);
        for (int i = 0; i < PLAN_LEN; i++)
            send_reading(plan[i].rd, plan[i].typed, plan[i].want);
        rand_sent = 0;
        while (rand_sent < RAND_WORDS)
        begin
            // mostly short cycles, now and then one long enough to cap the count
            run_len = ($urandom_range(0, 59) == 0) ? $urandom_range(250, 270)
                                                    : $urandom_range(1, 16);
            o2_base = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535)
                                                  : near_mark(o2_marks[$urandom_range(0, 4)], 160);
            co2_base = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535)
                                                   : near_mark(co2_marks[$urandom_range(0, 4)], 160);
            run_active = ($urandom_range(0, 9) != 0);
            for (int k = 0; k < run_len; k++)
            begin
                if (rand_sent % 64 == 0)
                    no_idle = ($urandom_range(0, 3) == 0);
                r.o2 = near_mark(o2_base, 24);
                r.co2 = near_mark(co2_base, 24);
                r.brain = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 65535))
                                                      : near_mark(brain_marks[$urandom_range(0, 3)], 40);
                r.myo = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 65535))
                                                    : near_mark(myo_marks[$urandom_range(0, 1)], 40);
                r.na = ($urandom_range(0, 7) == 0) ? 14'($urandom_range(0, 16383))
                                                   : 14'(near_mark(na_marks[$urandom_range(0, 3)], 40));
                r.start = (k == run_len - 1);
                r.active = run_active;
                r.past = ($urandom_range(0, 6) != 0);
                // occasional noise word with every field drawn at random
                if ($urandom_range(0, 15) == 0)
                begin
                    r.o2 = 16'($urandom());
                    r.co2 = 16'($urandom());
                    r.brain = 16'($urandom());
                    r.myo = 16'($urandom());
                    r.na = 14'($urandom());
                    r.start = 1'($urandom());
                    r.active = 1'($urandom());
                    r.past = 1'($urandom());
                end
                send_reading(r, 1'b0, '0);
                rand_sent++;
            end
        end
        s_tvalid <= 1'b0;
        // drain, then allow time for any stray word
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        $display("checked %0d output words over %0d directed and %0d random inputs",
                 words_checked, PLAN_LEN, rand_sent);
        $display("%0d cycle alarm evaluations, %0d cycles reached the sample cap",
                 cycle_evals, capped_cycles);
        if (errors == 0)
            $display("** blood_gas_hysteresis_alarm_monitor: PASSED **");
        else
            $display("** blood_gas_hysteresis_alarm_monitor: FAILED **");
        $finish;
    end

endmodule

FILE: sim.f
rtl/bgham_pkg.sv
rtl/bgham_alarm.sv
rtl/bgham_dp.sv
rtl/bgham_ctrl.sv
rtl/blood_gas_hysteresis_alarm_monitor.sv
verif/tb_top.sv
